FILE: rtl/gmb_pkg.sv
// gmb_pkg: shared types, codes and constants of the greedy meshlet builder
// used by gmb_lane, gmb_merge, gmb_emit and greedy_meshlet_builder
// no dependencies
package gmb_pkg;

    localparam int MAX_VERTS_DEF = 64;
    localparam int MAX_TRIS_DEF  = 128;

    localparam int NUM_CORNERS = 3;
    localparam int NUM_STEPS   = 8;
    localparam int IDX_W       = 32;
    localparam int CFG_W       = 8;
    localparam int MAXV_W      = 7;
    localparam int MAXT_W      = 8;
    localparam int VCNT_OUT_W  = 7;
    localparam int TCNT_OUT_W  = 8;
    localparam int FIFO_DEPTH  = 2;

    localparam int VLIM_MIN    = 3;
    localparam int TLIM_MIN    = 1;
    localparam int INDEX_STEP  = 3;
    localparam int TRI_STEP    = 1;

    localparam logic [MAXV_W-1:0] MAXV_RESET = 7'd64;
    localparam logic [MAXT_W-1:0] MAXT_RESET = 8'd128;

    // configuration register indexes
    localparam logic REG_MAX_VERTICES  = 1'b0;
    localparam logic REG_MAX_TRIANGLES = 1'b1;

    // result beat kinds
    typedef enum logic [1:0] {
        KIND_MAP   = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    // beat sequence of one triangle, in emission order
    localparam logic [2:0] STEP_CLOSE_FIRST = 3'd0;
    localparam logic [2:0] STEP_MAP_A       = 3'd1;
    localparam logic [2:0] STEP_LOC_A       = 3'd2;
    localparam logic [2:0] STEP_MAP_B       = 3'd3;
    localparam logic [2:0] STEP_LOC_B       = 3'd4;
    localparam logic [2:0] STEP_MAP_C       = 3'd5;
    localparam logic [2:0] STEP_LOC_C       = 3'd6;
    localparam logic [2:0] STEP_CLOSE_LAST  = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]      voff;
        logic [IDX_W-1:0]      ioff;
        logic [VCNT_OUT_W-1:0] vcnt;
        logic [TCNT_OUT_W-1:0] tcnt;
    } t_close;

    typedef struct packed {
        logic                 push;
        logic [NUM_STEPS-1:0] steps;
    } t_desc_ctl;

endpackage

FILE: rtl/greedy_meshlet_builder.sv
// greedy_meshlet_builder: top level, remap table, running counters and configuration
// instantiates three gmb_lane, one gmb_merge and one gmb_emit
// depends on gmb_pkg
//
// Takes one triangle per input beat (three global vertex indices and an end-of-mesh
// mark) and packs triangles greedily into meshlets of at most max_vertices vertices
// and max_triangles triangles. Each corner has its own lane that matches it against
// every open table slot in parallel; a merge stage then resolves repeats inside the
// triangle, decides whether the open meshlet must close first and updates the state.
// A triangle is registered in the lanes and then merged, so the input takes no beat
// while a merge is pending and only while the two-entry result queue has room.
// Results leave one beat per cycle while i_out_ready is high, 3 to 8 beats per
// triangle (optional close record, a vertex-map beat for each new corner, a
// local-index beat per corner, a final close record at end of mesh), so the
// result channel sets the sustained rate. o_last marks the final beat of a triangle.
// The remap table needs no clearing after reset: only slots below the fill count
// are ever matched. Configuration writes take effect at once and are meant for idle
// periods; limits clamp to 3..MAX_VERTS (on the low 7 data bits) and 1..MAX_TRIS.
module greedy_meshlet_builder #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRIS  = gmb_pkg::MAX_TRIS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0]         i_cfg_data,
    // triangle input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gmb_pkg::IDX_W-1:0]         i_corner_a,
    input  logic [gmb_pkg::IDX_W-1:0]         i_corner_b,
    input  logic [gmb_pkg::IDX_W-1:0]         i_corner_c,
    input  logic                              i_end_of_mesh,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_kind,
    output logic [gmb_pkg::IDX_W-1:0]         o_index_value,
    output logic [gmb_pkg::IDX_W-1:0]         o_vertex_offset,
    output logic [gmb_pkg::IDX_W-1:0]         o_index_offset,
    output logic [gmb_pkg::VCNT_OUT_W-1:0]    o_vertex_count,
    output logic [gmb_pkg::TCNT_OUT_W-1:0]    o_triangle_count,
    output logic                              o_last
);
    localparam int VW = $clog2(MAX_VERTS + 1);
    localparam int SW = $clog2(MAX_VERTS);
    localparam int TW = $clog2(MAX_TRIS + 1);

    // configuration registers
    logic [gmb_pkg::MAXV_W-1:0] r_max_vertices;
    logic [gmb_pkg::MAXT_W-1:0] r_max_triangles;

    // open meshlet state, table is flops each watched by its own comparators
    logic [gmb_pkg::IDX_W-1:0]  r_table [MAX_VERTS];
    logic [VW-1:0]              r_vcnt;
    logic [TW-1:0]              r_tcnt;
    logic [gmb_pkg::IDX_W-1:0]  r_map_total, r_index_total, r_vbase, r_ibase;

    // triangle held between lane compare and merge
    logic                       r_lane_vld;
    logic [gmb_pkg::IDX_W-1:0]  r_corner [gmb_pkg::NUM_CORNERS];
    logic                       r_eq_ab, r_eq_ac, r_eq_bc, r_eom;

    logic                       in_beat;
    logic                       space;
    logic [gmb_pkg::IDX_W-1:0]  w_corner [gmb_pkg::NUM_CORNERS];
    logic                       lane_hit  [gmb_pkg::NUM_CORNERS];
    logic [SW-1:0]              lane_slot [gmb_pkg::NUM_CORNERS];

    // merge results
    logic                       mg_new  [gmb_pkg::NUM_CORNERS];
    logic [SW-1:0]              mg_slot [gmb_pkg::NUM_CORNERS];
    logic [VW-1:0]              n_vcnt;
    logic [TW-1:0]              n_tcnt;
    logic [gmb_pkg::IDX_W-1:0]  n_map_total, n_index_total, n_vbase, n_ibase;
    gmb_pkg::t_desc_ctl         mg_ctl;
    gmb_pkg::t_close            mg_close_first, mg_close_last, out_close;
    gmb_pkg::t_kind             out_kind;

    // the lanes see the table only after the previous triangle has merged
    assign o_in_ready = !r_lane_vld && space;
    assign in_beat    = i_in_valid && o_in_ready;

    assign w_corner[0] = i_corner_a;
    assign w_corner[1] = i_corner_b;
    assign w_corner[2] = i_corner_c;

    for (genvar g = 0; g < gmb_pkg::NUM_CORNERS; g++) begin : g_lane
        gmb_lane #(
            .MAX_VERTS (MAX_VERTS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_load   (in_beat),
            .i_corner (w_corner[g]),
            .i_table  (r_table),
            .i_count  (r_vcnt),
            .o_hit    (lane_hit[g]),
            .o_slot   (lane_slot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_corner <= w_corner;
            r_eq_ab  <= (i_corner_a == i_corner_b);
            r_eq_ac  <= (i_corner_a == i_corner_c);
            r_eq_bc  <= (i_corner_b == i_corner_c);
            r_eom    <= i_end_of_mesh;
        end
    end

    gmb_merge #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_TRIS  (MAX_TRIS)
    ) u_merge (
        .i_valid         (r_lane_vld),
        .i_hit           (lane_hit),
        .i_slot          (lane_slot),
        .i_eq_ab         (r_eq_ab),
        .i_eq_ac         (r_eq_ac),
        .i_eq_bc         (r_eq_bc),
        .i_eom           (r_eom),
        .i_max_vertices  (r_max_vertices),
        .i_max_triangles (r_max_triangles),
        .i_vcnt          (r_vcnt),
        .i_tcnt          (r_tcnt),
        .i_map_total     (r_map_total),
        .i_index_total   (r_index_total),
        .i_vbase         (r_vbase),
        .i_ibase         (r_ibase),
        .o_new           (mg_new),
        .o_slot          (mg_slot),
        .o_vcnt          (n_vcnt),
        .o_tcnt          (n_tcnt),
        .o_map_total     (n_map_total),
        .o_index_total   (n_index_total),
        .o_vbase         (n_vbase),
        .o_ibase         (n_ibase),
        .o_ctl           (mg_ctl),
        .o_close_first   (mg_close_first),
        .o_close_last    (mg_close_last)
    );

    // new corners land in their assigned slots, up to three per merge
    always_ff @(posedge i_clk) begin
        if (r_lane_vld) begin
            for (int i = 0; i < MAX_VERTS; i++) begin
                if (mg_new[0] && (mg_slot[0] == SW'(i))) begin
                    r_table[i] <= r_corner[0];
                end else if (mg_new[1] && (mg_slot[1] == SW'(i))) begin
                    r_table[i] <= r_corner[1];
                end else if (mg_new[2] && (mg_slot[2] == SW'(i))) begin
                    r_table[i] <= r_corner[2];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vertices  <= gmb_pkg::MAXV_RESET;
            r_max_triangles <= gmb_pkg::MAXT_RESET;
            r_lane_vld      <= 1'b0;
            r_vcnt          <= '0;
            r_tcnt          <= '0;
            r_map_total     <= '0;
            r_index_total   <= '0;
            r_vbase         <= '0;
            r_ibase         <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gmb_pkg::REG_MAX_VERTICES) begin
                    r_max_vertices <= i_cfg_data[gmb_pkg::MAXV_W-1:0];
                end else if (i_cfg_index == gmb_pkg::REG_MAX_TRIANGLES) begin
                    r_max_triangles <= i_cfg_data;
                end
            end
            r_lane_vld <= in_beat;
            if (r_lane_vld) begin
                r_vcnt        <= n_vcnt;
                r_tcnt        <= n_tcnt;
                r_map_total   <= n_map_total;
                r_index_total <= n_index_total;
                r_vbase       <= n_vbase;
                r_ibase       <= n_ibase;
            end
        end
    end

    gmb_emit #(
        .MAX_VERTS (MAX_VERTS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (mg_ctl),
        .i_glob        (r_corner),
        .i_slot        (mg_slot),
        .i_close_first (mg_close_first),
        .i_close_last  (mg_close_last),
        .o_space       (space),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_kind        (out_kind),
        .o_value       (o_index_value),
        .o_close       (out_close),
        .o_last        (o_last)
    );

    assign o_kind           = out_kind;
    assign o_vertex_offset  = out_close.voff;
    assign o_index_offset   = out_close.ioff;
    assign o_vertex_count   = out_close.vcnt;
    assign o_triangle_count = out_close.tcnt;

    // the fill count never passes the table depth
    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VW'(MAX_VERTS))
        else $error("open vertex count beyond table depth");

    a_tcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TW'(MAX_TRIS))
        else $error("open triangle count beyond limit");

    // a merged triangle that does not end the mesh leaves an open meshlet behind
    a_open_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane_vld && !r_eom |=> (r_tcnt != '0) && (r_vcnt != '0))
        else $error("merged triangle left an empty meshlet");

    // no new triangle reaches the lanes before the previous one has merged
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane_vld |-> !in_beat)
        else $error("triangle accepted while merge pending");

    // the queue always has room for the triangle being merged
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane_vld |-> space)
        else $error("merge push into a full result queue");

endmodule

FILE: rtl/gmb_lane.sv
// gmb_lane: one corner lane, matches a global index against the open remap table
// registers the hit vector at accept, then encodes the matching slot
// depends on gmb_pkg
module gmb_lane #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [gmb_pkg::IDX_W-1:0]      i_corner,
    input  logic [gmb_pkg::IDX_W-1:0]      i_table [MAX_VERTS],
    input  logic [$clog2(MAX_VERTS+1)-1:0] i_count,
    output logic                           o_hit,
    output logic [$clog2(MAX_VERTS)-1:0]   o_slot
);
    localparam int VW = $clog2(MAX_VERTS + 1);
    localparam int SW = $clog2(MAX_VERTS);

    logic [MAX_VERTS-1:0] r_hits;
    logic [MAX_VERTS-1:0] n_hits;

    // only slots below the fill count belong to the open meshlet
    always_comb begin
        for (int i = 0; i < MAX_VERTS; i++) begin
            n_hits[i] = (VW'(i) < i_count) && (i_table[i] == i_corner);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hits <= n_hits;
        end
    end

    // table entries are unique, so at most one bit is set
    always_comb begin
        o_slot = '0;
        for (int i = 0; i < MAX_VERTS; i++) begin
            if (r_hits[i]) begin
                o_slot = o_slot | SW'(i);
            end
        end
    end

    assign o_hit = |r_hits;

endmodule

FILE: rtl/gmb_merge.sv
// gmb_merge: combines the three lane results into slots, close decisions and next state
// purely combinational, consumed by the top level registers and gmb_emit
// depends on gmb_pkg
module gmb_merge #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRIS  = gmb_pkg::MAX_TRIS_DEF
) (
    input  logic                            i_valid,
    input  logic                            i_hit  [gmb_pkg::NUM_CORNERS],
    input  logic [$clog2(MAX_VERTS)-1:0]    i_slot [gmb_pkg::NUM_CORNERS],
    input  logic                            i_eq_ab,
    input  logic                            i_eq_ac,
    input  logic                            i_eq_bc,
    input  logic                            i_eom,
    input  logic [gmb_pkg::MAXV_W-1:0]      i_max_vertices,
    input  logic [gmb_pkg::MAXT_W-1:0]      i_max_triangles,
    input  logic [$clog2(MAX_VERTS+1)-1:0]  i_vcnt,
    input  logic [$clog2(MAX_TRIS+1)-1:0]   i_tcnt,
    input  logic [gmb_pkg::IDX_W-1:0]       i_map_total,
    input  logic [gmb_pkg::IDX_W-1:0]       i_index_total,
    input  logic [gmb_pkg::IDX_W-1:0]       i_vbase,
    input  logic [gmb_pkg::IDX_W-1:0]       i_ibase,
    output logic                            o_new  [gmb_pkg::NUM_CORNERS],
    output logic [$clog2(MAX_VERTS)-1:0]    o_slot [gmb_pkg::NUM_CORNERS],
    output logic [$clog2(MAX_VERTS+1)-1:0]  o_vcnt,
    output logic [$clog2(MAX_TRIS+1)-1:0]   o_tcnt,
    output logic [gmb_pkg::IDX_W-1:0]       o_map_total,
    output logic [gmb_pkg::IDX_W-1:0]       o_index_total,
    output logic [gmb_pkg::IDX_W-1:0]       o_vbase,
    output logic [gmb_pkg::IDX_W-1:0]       o_ibase,
    output gmb_pkg::t_desc_ctl              o_ctl,
    output gmb_pkg::t_close                 o_close_first,
    output gmb_pkg::t_close                 o_close_last
);
    localparam int VW  = $clog2(MAX_VERTS + 1);
    localparam int SW  = $clog2(MAX_VERTS);
    localparam int TW  = $clog2(MAX_TRIS + 1);
    localparam int LW  = ((VW > gmb_pkg::MAXV_W) ? VW : gmb_pkg::MAXV_W) + 1;
    localparam int TLW = ((TW > gmb_pkg::MAXT_W) ? TW : gmb_pkg::MAXT_W) + 1;

    logic [LW-1:0]  mv, vlim, fresh;
    logic [TLW-1:0] mt, tlim;
    logic           close_first;
    logic           h_a, h_b, h_c;
    logic           new_a, new_b, new_c;
    logic           dup_b, dup_ca, dup_cb;
    logic [SW-1:0]  sl_a, sl_b, sl_c;
    logic [VW-1:0]  c0, vcnt_a;
    logic [TW-1:0]  tcnt_a;
    logic [1:0]     added;
    logic [gmb_pkg::IDX_W-1:0] vbase_a, ibase_a, map_a, index_a;

    // clamp the limits so an empty meshlet always takes a triangle
    always_comb begin
        mv = LW'(i_max_vertices);
        if (mv < LW'(gmb_pkg::VLIM_MIN)) begin
            vlim = LW'(gmb_pkg::VLIM_MIN);
        end else if (mv > LW'(MAX_VERTS)) begin
            vlim = LW'(MAX_VERTS);
        end else begin
            vlim = mv;
        end
        mt = TLW'(i_max_triangles);
        if (mt < TLW'(gmb_pkg::TLIM_MIN)) begin
            tlim = TLW'(gmb_pkg::TLIM_MIN);
        end else if (mt > TLW'(MAX_TRIS)) begin
            tlim = TLW'(MAX_TRIS);
        end else begin
            tlim = mt;
        end
    end

    // a repeated new index counts once per corner here
    assign fresh = LW'(!i_hit[0]) + LW'(!i_hit[1]) + LW'(!i_hit[2]);
    assign close_first = (LW'(i_vcnt) + fresh > vlim)
                      || (TLW'(i_tcnt) + TLW'(gmb_pkg::TRI_STEP) > tlim);

    // after a close the table is empty
    assign h_a = i_hit[0] && !close_first;
    assign h_b = i_hit[1] && !close_first;
    assign h_c = i_hit[2] && !close_first;
    assign c0  = close_first ? '0 : i_vcnt;

    always_comb begin
        new_a  = !h_a;
        sl_a   = h_a ? i_slot[0] : SW'(c0);
        dup_b  = new_a && i_eq_ab;
        new_b  = !h_b && !dup_b;
        sl_b   = h_b ? i_slot[1] : (dup_b ? sl_a : SW'(c0 + VW'(new_a)));
        dup_ca = new_a && i_eq_ac;
        dup_cb = new_b && i_eq_bc;
        new_c  = !h_c && !dup_ca && !dup_cb;
        if (h_c) begin
            sl_c = i_slot[2];
        end else if (dup_ca) begin
            sl_c = sl_a;
        end else if (dup_cb) begin
            sl_c = sl_b;
        end else begin
            sl_c = SW'(c0 + VW'(new_a) + VW'(new_b));
        end
    end

    assign added   = 2'(new_a) + 2'(new_b) + 2'(new_c);
    assign vcnt_a  = c0 + VW'(added);
    assign tcnt_a  = (close_first ? '0 : i_tcnt) + TW'(gmb_pkg::TRI_STEP);
    assign vbase_a = close_first ? i_map_total : i_vbase;
    assign ibase_a = close_first ? i_index_total : i_ibase;
    assign map_a   = i_map_total + gmb_pkg::IDX_W'(added);
    assign index_a = i_index_total + gmb_pkg::IDX_W'(gmb_pkg::INDEX_STEP);

    assign o_new[0]  = new_a;
    assign o_new[1]  = new_b;
    assign o_new[2]  = new_c;
    assign o_slot[0] = sl_a;
    assign o_slot[1] = sl_b;
    assign o_slot[2] = sl_c;

    // end of mesh returns the running state to zero
    always_comb begin
        if (i_eom) begin
            o_vcnt        = '0;
            o_tcnt        = '0;
            o_map_total   = '0;
            o_index_total = '0;
            o_vbase       = '0;
            o_ibase       = '0;
        end else begin
            o_vcnt        = vcnt_a;
            o_tcnt        = tcnt_a;
            o_map_total   = map_a;
            o_index_total = index_a;
            o_vbase       = vbase_a;
            o_ibase       = ibase_a;
        end
    end

    always_comb begin
        o_ctl.push  = i_valid;
        o_ctl.steps = '0;
        o_ctl.steps[gmb_pkg::STEP_CLOSE_FIRST] = close_first;
        o_ctl.steps[gmb_pkg::STEP_MAP_A]       = new_a;
        o_ctl.steps[gmb_pkg::STEP_LOC_A]       = 1'b1;
        o_ctl.steps[gmb_pkg::STEP_MAP_B]       = new_b;
        o_ctl.steps[gmb_pkg::STEP_LOC_B]       = 1'b1;
        o_ctl.steps[gmb_pkg::STEP_MAP_C]       = new_c;
        o_ctl.steps[gmb_pkg::STEP_LOC_C]       = 1'b1;
        o_ctl.steps[gmb_pkg::STEP_CLOSE_LAST]  = i_eom;
    end

    assign o_close_first.voff = i_vbase;
    assign o_close_first.ioff = i_ibase;
    assign o_close_first.vcnt = gmb_pkg::VCNT_OUT_W'(i_vcnt);
    assign o_close_first.tcnt = gmb_pkg::TCNT_OUT_W'(i_tcnt);
    assign o_close_last.voff  = vbase_a;
    assign o_close_last.ioff  = ibase_a;
    assign o_close_last.vcnt  = gmb_pkg::VCNT_OUT_W'(vcnt_a);
    assign o_close_last.tcnt  = gmb_pkg::TCNT_OUT_W'(tcnt_a);

endmodule

FILE: rtl/gmb_emit.sv
// gmb_emit: two-entry queue of triangle descriptors and the result beat sequencer
// walks the enabled steps of the head descriptor, one beat per handshake
// depends on gmb_pkg
module gmb_emit #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gmb_pkg::t_desc_ctl            i_ctl,
    input  logic [gmb_pkg::IDX_W-1:0]     i_glob [gmb_pkg::NUM_CORNERS],
    input  logic [$clog2(MAX_VERTS)-1:0]  i_slot [gmb_pkg::NUM_CORNERS],
    input  gmb_pkg::t_close               i_close_first,
    input  gmb_pkg::t_close               i_close_last,
    output logic                          o_space,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gmb_pkg::t_kind                o_kind,
    output logic [gmb_pkg::IDX_W-1:0]     o_value,
    output gmb_pkg::t_close               o_close,
    output logic                          o_last
);
    localparam int SW = $clog2(MAX_VERTS);

    logic [gmb_pkg::NUM_STEPS-1:0] r_steps [gmb_pkg::FIFO_DEPTH];
    logic [gmb_pkg::IDX_W-1:0]     r_glob  [gmb_pkg::FIFO_DEPTH][gmb_pkg::NUM_CORNERS];
    logic [SW-1:0]                 r_slot  [gmb_pkg::FIFO_DEPTH][gmb_pkg::NUM_CORNERS];
    gmb_pkg::t_close               r_close_first [gmb_pkg::FIFO_DEPTH];
    gmb_pkg::t_close               r_close_last  [gmb_pkg::FIFO_DEPTH];
    logic                          r_wr, r_rd;
    logic [1:0]                    r_cnt;

    logic [gmb_pkg::NUM_STEPS-1:0] head, low, rest;
    logic [2:0]                    step;
    logic                          beat, pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt < 2'(gmb_pkg::FIFO_DEPTH));

    // current step is the lowest pending one
    assign head   = r_steps[r_rd];
    assign low    = head & (~head + gmb_pkg::NUM_STEPS'(1));
    assign rest   = head & ~low;
    assign o_last = (rest == '0);
    assign beat   = o_valid && i_ready;
    assign pop    = beat && o_last;

    always_comb begin
        step = '0;
        for (int i = 0; i < gmb_pkg::NUM_STEPS; i++) begin
            if (low[i]) begin
                step = step | 3'(i);
            end
        end
    end

    always_comb begin
        o_close = '0;
        o_value = '0;
        unique case (step)
            gmb_pkg::STEP_CLOSE_FIRST: begin
                o_kind  = gmb_pkg::KIND_CLOSE;
                o_close = r_close_first[r_rd];
            end
            gmb_pkg::STEP_MAP_A: begin
                o_kind  = gmb_pkg::KIND_MAP;
                o_value = r_glob[r_rd][0];
            end
            gmb_pkg::STEP_LOC_A: begin
                o_kind  = gmb_pkg::KIND_LOCAL;
                o_value = gmb_pkg::IDX_W'(r_slot[r_rd][0]);
            end
            gmb_pkg::STEP_MAP_B: begin
                o_kind  = gmb_pkg::KIND_MAP;
                o_value = r_glob[r_rd][1];
            end
            gmb_pkg::STEP_LOC_B: begin
                o_kind  = gmb_pkg::KIND_LOCAL;
                o_value = gmb_pkg::IDX_W'(r_slot[r_rd][1]);
            end
            gmb_pkg::STEP_MAP_C: begin
                o_kind  = gmb_pkg::KIND_MAP;
                o_value = r_glob[r_rd][2];
            end
            gmb_pkg::STEP_LOC_C: begin
                o_kind  = gmb_pkg::KIND_LOCAL;
                o_value = gmb_pkg::IDX_W'(r_slot[r_rd][2]);
            end
            gmb_pkg::STEP_CLOSE_LAST: begin
                o_kind  = gmb_pkg::KIND_CLOSE;
                o_close = r_close_last[r_rd];
            end
            default: begin
                o_kind  = gmb_pkg::KIND_CLOSE;
            end
        endcase
    end

    // a push never lands on the head entry while it is being drained
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_steps[r_wr]       <= i_ctl.steps;
            r_glob[r_wr]        <= i_glob;
            r_slot[r_wr]        <= i_slot;
            r_close_first[r_wr] <= i_close_first;
            r_close_last[r_wr]  <= i_close_last;
        end
        if (beat && !o_last) begin
            r_steps[r_rd] <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_ctl.push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_ctl.push) - 2'(pop);
        end
    end

endmodule
